// ===== rtl/core/mcwd_pkg.sv =====
package mcwd_pkg;

    localparam logic [1:0] CMD_REGISTER = 2'd0;
    localparam logic [1:0] CMD_FEED     = 2'd1;
    localparam logic [1:0] CMD_TICK     = 2'd2;

    localparam logic [1:0] KIND_OWN   = 2'd0;
    localparam logic [1:0] KIND_OTHER = 2'd1;
    localparam logic [1:0] KIND_IDLE  = 2'd2;
    localparam logic [1:0] KIND_ACK   = 2'd3;

    localparam logic [15:0] DEFAULT_COUNT = 16'd100;

    localparam int STEP_W = 5;

    typedef struct packed {
        logic [1:0]  command;
        logic [2:0]  slot;
        logic [7:0]  owner;
        logic [15:0] reload_value;
        logic [15:0] initial_value;
        logic        notify_self;
        logic        notify_others;
    } t_cmd_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] notified_owner;
        logic [2:0] expired_slot;
        logic       error;
        logic       last;
    } t_result;

    typedef enum logic [3:0] {
        A_NONE,
        A_ERR,
        A_REG,
        A_FEED,
        A_TICK_INIT,
        A_CLR_I,
        A_DEC,
        A_SELF,
        A_CLR_J,
        A_OTHER,
        A_INC_I,
        A_FLUSH
    } t_act;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_NEVER,
        C_NOSTART,
        C_REG,
        C_FEED,
        C_TICK,
        C_I_END,
        C_J_END,
        C_NO_OTH
    } t_cond;

    typedef struct packed {
        t_act              act;
        t_cond             cond;
        logic [STEP_W-1:0] target;
    } t_uop;

endpackage

// ===== rtl/core/multi_channel_watchdog.sv =====
// Register, feed and unknown commands: one acknowledge.
// Tick: timeout notices, then a final result, paced by the step counter walking the slot loops
// over the registered channels and, for each slot with the others flag, the nested slot loop.
// One item at a time: busy drops as the final result is strobed; results cannot be stalled.
// Synchronous active-low reset clears the channel count and the sequencer, not the slot stores.
module multi_channel_watchdog
    import mcwd_pkg::*;
#(
    parameter int MAX_CHANNELS = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_cmd_item i_item,
    output t_result   o_result,
    output logic      o_strobe
);

    localparam int CW = $clog2(MAX_CHANNELS + 1);
    localparam int IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    localparam logic [STEP_W-1:0] S_WAIT      = 5'd0;
    localparam logic [STEP_W-1:0] S_REG       = 5'd5;
    localparam logic [STEP_W-1:0] S_FEED      = 5'd6;
    localparam logic [STEP_W-1:0] S_TICK      = 5'd7;
    localparam logic [STEP_W-1:0] S_DEC_TEST  = 5'd8;
    localparam logic [STEP_W-1:0] S_SELF_INIT = 5'd10;
    localparam logic [STEP_W-1:0] S_SELF_TEST = 5'd11;
    localparam logic [STEP_W-1:0] S_OTH_INIT  = 5'd13;
    localparam logic [STEP_W-1:0] S_OTH_TEST  = 5'd14;
    localparam logic [STEP_W-1:0] S_IN_TEST   = 5'd16;
    localparam logic [STEP_W-1:0] S_OTH_NEXT  = 5'd18;
    localparam logic [STEP_W-1:0] S_FLUSH     = 5'd19;

    function automatic t_uop rom(input logic [STEP_W-1:0] s);
        t_uop u;
        case (s)
            5'd0:    u = '{act: A_NONE,      cond: C_NOSTART, target: S_WAIT};
            5'd1:    u = '{act: A_NONE,      cond: C_REG,     target: S_REG};
            5'd2:    u = '{act: A_NONE,      cond: C_FEED,    target: S_FEED};
            5'd3:    u = '{act: A_NONE,      cond: C_TICK,    target: S_TICK};
            5'd4:    u = '{act: A_ERR,       cond: C_ALWAYS,  target: S_WAIT};
            5'd5:    u = '{act: A_REG,       cond: C_ALWAYS,  target: S_WAIT};
            5'd6:    u = '{act: A_FEED,      cond: C_ALWAYS,  target: S_WAIT};
            5'd7:    u = '{act: A_TICK_INIT, cond: C_NEVER,   target: S_WAIT};
            5'd8:    u = '{act: A_NONE,      cond: C_I_END,   target: S_SELF_INIT};
            5'd9:    u = '{act: A_DEC,       cond: C_ALWAYS,  target: S_DEC_TEST};
            5'd10:   u = '{act: A_CLR_I,     cond: C_NEVER,   target: S_WAIT};
            5'd11:   u = '{act: A_NONE,      cond: C_I_END,   target: S_OTH_INIT};
            5'd12:   u = '{act: A_SELF,      cond: C_ALWAYS,  target: S_SELF_TEST};
            5'd13:   u = '{act: A_CLR_I,     cond: C_NEVER,   target: S_WAIT};
            5'd14:   u = '{act: A_NONE,      cond: C_I_END,   target: S_FLUSH};
            5'd15:   u = '{act: A_CLR_J,     cond: C_NO_OTH,  target: S_OTH_NEXT};
            5'd16:   u = '{act: A_NONE,      cond: C_J_END,   target: S_OTH_NEXT};
            5'd17:   u = '{act: A_OTHER,     cond: C_ALWAYS,  target: S_IN_TEST};
            5'd18:   u = '{act: A_INC_I,     cond: C_ALWAYS,  target: S_OTH_TEST};
            5'd19:   u = '{act: A_FLUSH,     cond: C_ALWAYS,  target: S_WAIT};
            default: u = '{act: A_NONE,      cond: C_ALWAYS,  target: S_WAIT};
        endcase
        return u;
    endfunction

    logic [STEP_W-1:0]     r_step, n_step;
    t_cmd_item             r_item;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [CW-1:0]         r_i, n_i;
    logic [CW-1:0]         r_j, n_j;
    logic [MAX_CHANNELS-1:0] r_exp, n_exp;
    logic                  r_pend_valid, n_pend_valid;
    t_result               r_pend, n_pend;
    t_result               r_out, n_out;
    logic                  r_strobe, n_strobe;

    logic [15:0] r_ctr [MAX_CHANNELS];
    logic [15:0] r_rel [MAX_CHANNELS];
    logic [7:0]  r_own [MAX_CHANNELS];
    logic [1:0]  r_flg [MAX_CHANNELS];

    t_uop        uop;
    logic        cond_hit;
    logic [IW-1:0] rd_addr;
    logic [15:0] rd_ctr;
    logic [15:0] rd_rel;
    logic [7:0]  rd_own;
    logic [1:0]  rd_flg;
    logic [15:0] ctr_dec;
    logic        reg_we;
    logic        ctr_we;
    logic [15:0] ctr_wdata;
    logic        new_valid;
    t_result     new_res;
    logic [3:0]  slot_ext;
    logic [3:0]  cnt_ext;
    logic        table_full;

    assign uop        = rom(r_step);
    assign busy       = (r_step != S_WAIT);
    assign rd_addr    = (uop.act == A_FEED) ? r_item.slot[IW-1:0] : r_i[IW-1:0];
    assign rd_ctr     = r_ctr[rd_addr];
    assign rd_rel     = r_rel[rd_addr];
    assign rd_own     = r_own[rd_addr];
    assign rd_flg     = r_flg[rd_addr];
    assign ctr_dec    = (rd_ctr == 16'd0) ? 16'd0 : rd_ctr - 16'd1;
    assign slot_ext   = {1'b0, r_item.slot};
    assign cnt_ext    = 4'(r_cnt);
    assign table_full = (r_cnt >= CW'(MAX_CHANNELS));

    always_comb begin
        case (uop.cond)
            C_ALWAYS: cond_hit = 1'b1;
            C_NEVER:  cond_hit = 1'b0;
            C_NOSTART: cond_hit = !start;
            C_REG:    cond_hit = (r_item.command == CMD_REGISTER);
            C_FEED:   cond_hit = (r_item.command == CMD_FEED);
            C_TICK:   cond_hit = (r_item.command == CMD_TICK);
            C_I_END:  cond_hit = (r_i == r_cnt);
            C_J_END:  cond_hit = (r_j == r_cnt);
            C_NO_OTH: cond_hit = !rd_flg[1];
            default:  cond_hit = 1'b0;
        endcase
    end

    always_comb begin
        n_step       = cond_hit ? uop.target : r_step + STEP_W'(1);
        n_cnt        = r_cnt;
        n_i          = r_i;
        n_j          = r_j;
        n_exp        = r_exp;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        n_out        = r_out;
        n_strobe     = 1'b0;
        reg_we       = 1'b0;
        ctr_we       = 1'b0;
        ctr_wdata    = ctr_dec;
        new_valid    = 1'b0;
        new_res      = '{kind: KIND_OWN, notified_owner: rd_own,
                         expired_slot: 3'(r_i), error: 1'b0, last: 1'b0};

        case (uop.act)
            A_ERR: begin
                n_strobe = 1'b1;
                n_out    = '{kind: KIND_ACK, notified_owner: 8'd0,
                             expired_slot: 3'd0, error: 1'b1, last: 1'b1};
            end
            A_REG: begin
                n_strobe = 1'b1;
                if (table_full) begin
                    n_out = '{kind: KIND_ACK, notified_owner: r_item.owner,
                              expired_slot: 3'd0, error: 1'b1, last: 1'b1};
                end else begin
                    reg_we = 1'b1;
                    n_cnt  = r_cnt + CW'(1);
                    n_out  = '{kind: KIND_ACK, notified_owner: r_item.owner,
                               expired_slot: 3'(r_cnt), error: 1'b0, last: 1'b1};
                end
            end
            A_FEED: begin
                n_strobe = 1'b1;
                if (slot_ext < cnt_ext) begin
                    ctr_we    = 1'b1;
                    ctr_wdata = rd_rel;
                    n_out     = '{kind: KIND_ACK, notified_owner: rd_own,
                                  expired_slot: r_item.slot, error: 1'b0, last: 1'b1};
                end else begin
                    n_out = '{kind: KIND_ACK, notified_owner: 8'd0,
                              expired_slot: r_item.slot, error: 1'b1, last: 1'b1};
                end
            end
            A_TICK_INIT: begin
                n_i          = '0;
                n_exp        = '0;
                n_pend_valid = 1'b0;
            end
            A_CLR_I: begin
                n_i = '0;
            end
            A_DEC: begin
                ctr_we                = 1'b1;
                n_exp[r_i[IW-1:0]]    = (ctr_dec == 16'd0);
                n_i                   = r_i + CW'(1);
            end
            A_SELF: begin
                new_valid = r_exp[r_i[IW-1:0]] && rd_flg[0];
                n_i       = r_i + CW'(1);
            end
            A_CLR_J: begin
                n_j = '0;
            end
            A_OTHER: begin
                new_valid = (r_j != r_i) && r_exp[r_j[IW-1:0]];
                new_res   = '{kind: KIND_OTHER, notified_owner: rd_own,
                              expired_slot: 3'(r_j), error: 1'b0, last: 1'b0};
                n_j       = r_j + CW'(1);
            end
            A_INC_I: begin
                n_i = r_i + CW'(1);
            end
            A_FLUSH: begin
                n_strobe     = 1'b1;
                n_pend_valid = 1'b0;
                if (r_pend_valid) begin
                    n_out      = r_pend;
                    n_out.last = 1'b1;
                end else begin
                    n_out = '{kind: KIND_IDLE, notified_owner: 8'd0,
                              expired_slot: 3'd0, error: 1'b0, last: 1'b1};
                end
            end
            default: begin
            end
        endcase

        // hold one notice back so the final one can carry last
        if (new_valid) begin
            if (r_pend_valid) begin
                n_strobe = 1'b1;
                n_out    = r_pend;
            end
            n_pend       = new_res;
            n_pend_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= S_WAIT;
            r_cnt        <= '0;
            r_i          <= '0;
            r_j          <= '0;
            r_exp        <= '0;
            r_pend_valid <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_step       <= n_step;
            r_cnt        <= n_cnt;
            r_i          <= n_i;
            r_j          <= n_j;
            r_exp        <= n_exp;
            r_pend_valid <= n_pend_valid;
            r_strobe     <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_out  <= n_out;
        if (r_step == S_WAIT && start) begin
            r_item <= i_item;
        end
        if (reg_we) begin
            r_own[r_cnt[IW-1:0]] <= r_item.owner;
            r_rel[r_cnt[IW-1:0]] <= (r_item.reload_value == 16'd0) ?
                                    DEFAULT_COUNT : r_item.reload_value;
            r_ctr[r_cnt[IW-1:0]] <= (r_item.initial_value == 16'd0) ?
                                    DEFAULT_COUNT : r_item.initial_value;
            r_flg[r_cnt[IW-1:0]] <= {r_item.notify_others, r_item.notify_self};
        end else if (ctr_we) begin
            r_ctr[rd_addr] <= ctr_wdata;
        end
    end

    assign o_result = r_out;
    assign o_strobe = r_strobe;

    a_strobe_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobed without an item in work");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_CHANNELS))
        else $error("channel count beyond table size");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last |=> !o_strobe)
        else $error("result strobed right after a final result");

    a_nonlast_is_notice: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.last |->
            (o_result.kind == KIND_OWN || o_result.kind == KIND_OTHER))
        else $error("non-final result is not a timeout notice");

endmodule
